@@ hw/rtl/pbrd_pkg.sv @@
package pbrd_pkg;

  localparam int unsigned MAX_ROW_BYTES = 65535;
  localparam int unsigned COUNT_W       = 17;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = 2;
  localparam int unsigned QCNT_W        = 3;

  localparam logic [7:0] CTL_NOOP = 8'h80;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       byte_valid;
    logic       row_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] run_length;
    logic       row_done;
    logic       row_error;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_CONTROL = 3'b001,
    PH_LITERAL = 3'b010,
    PH_REPEAT  = 3'b100
  } phase_t;

endpackage

@@ hw/rtl/pbrd_front.sv @@
module pbrd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  pbrd_pkg::in_item_t item,
  input  logic [15:0]        row_bytes,
  output logic               res_valid,
  output pbrd_pkg::out_item_t res
);

  pbrd_pkg::phase_t              phase, phase_next;
  logic [7:0]                    literal_left, literal_left_next;
  logic [pbrd_pkg::COUNT_W-1:0]  produced_count, produced_count_next;
  logic                          error_seen, error_seen_next;

  logic [pbrd_pkg::COUNT_W-1:0]  expected;
  logic [pbrd_pkg::COUNT_W-1:0]  add_n;
  logic [pbrd_pkg::COUNT_W-1:0]  sum;
  logic                          do_add;
  logic                          have;
  logic [7:0]                    rl;
  logic [8:0]                    rep_len;

  // expected size, capped at the row limit
  assign expected = ({1'b0, row_bytes} < pbrd_pkg::COUNT_W'(pbrd_pkg::MAX_ROW_BYTES))
                  ? {1'b0, row_bytes} : pbrd_pkg::COUNT_W'(pbrd_pkg::MAX_ROW_BYTES);

  assign rep_len = 9'd257 - {1'b0, item.code_byte};
  assign sum     = produced_count + add_n;

  always_comb begin
    phase_next          = phase;
    literal_left_next   = literal_left;
    produced_count_next = produced_count;
    error_seen_next     = error_seen;
    have                = 1'b0;
    rl                  = 8'd0;
    do_add              = 1'b0;
    add_n               = '0;

    if (item.byte_valid) begin
      unique case (phase)
        pbrd_pkg::PH_LITERAL: begin
          have              = 1'b1;
          rl                = 8'd1;
          do_add            = 1'b1;
          add_n             = pbrd_pkg::COUNT_W'(1);
          literal_left_next = literal_left - 8'd1;
          if (literal_left == 8'd1) begin
            phase_next = pbrd_pkg::PH_CONTROL;
          end
        end
        pbrd_pkg::PH_REPEAT: begin
          have              = 1'b1;
          rl                = literal_left;
          do_add            = 1'b1;
          add_n             = {{(pbrd_pkg::COUNT_W-8){1'b0}}, literal_left};
          literal_left_next = 8'd0;
          phase_next        = pbrd_pkg::PH_CONTROL;
        end
        pbrd_pkg::PH_CONTROL: begin
          if (produced_count < expected) begin
            if (!item.code_byte[7]) begin
              literal_left_next = item.code_byte + 8'd1;
              phase_next        = pbrd_pkg::PH_LITERAL;
            end else if (item.code_byte != pbrd_pkg::CTL_NOOP) begin
              literal_left_next = rep_len[7:0];
              phase_next        = pbrd_pkg::PH_REPEAT;
            end
          end
        end
        default: begin
          phase_next = pbrd_pkg::PH_CONTROL;
        end
      endcase
    end

    // count saturates one past the expected size
    if (do_add) begin
      if (sum > expected) begin
        error_seen_next     = 1'b1;
        produced_count_next = expected + pbrd_pkg::COUNT_W'(1);
      end else begin
        produced_count_next = sum;
      end
    end

    res.out_byte   = have ? item.code_byte : 8'd0;
    res.run_length = rl;
    res.row_done   = item.row_end;
    res.row_error  = item.row_end &&
                     ((phase_next != pbrd_pkg::PH_CONTROL) || error_seen_next ||
                      (produced_count_next != expected));
    res_valid      = in_valid && (have || item.row_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= pbrd_pkg::PH_CONTROL;
      literal_left   <= 8'd0;
      produced_count <= '0;
      error_seen     <= 1'b0;
    end else if (in_valid) begin
      if (item.row_end) begin
        phase          <= pbrd_pkg::PH_CONTROL;
        literal_left   <= 8'd0;
        produced_count <= '0;
        error_seen     <= 1'b0;
      end else begin
        phase          <= phase_next;
        literal_left   <= literal_left_next;
        produced_count <= produced_count_next;
        error_seen     <= error_seen_next;
      end
    end
  end

endmodule

@@ hw/rtl/pbrd_fifo.sv @@
module pbrd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  pbrd_pkg::out_item_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output pbrd_pkg::out_item_t rd_data,
  output logic                empty
);

  pbrd_pkg::out_item_t           slots [pbrd_pkg::QUEUE_DEPTH];
  logic [pbrd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [pbrd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [pbrd_pkg::QCNT_W-1:0]   count;
  logic                          do_wr;
  logic                          do_rd;

  assign full    = (count == pbrd_pkg::QCNT_W'(pbrd_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + pbrd_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + pbrd_pkg::QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + pbrd_pkg::QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - pbrd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/packbits_row_decoder_core.sv @@
// packbits row decoder
// input side is a queue write port: an encoded byte beat is taken on a
//   rising edge with push high and full low; byte_valid low with row_end
//   high closes the row without a byte, byte_valid low alone is an idle beat
// result side is a queue read port: while empty is low the oldest result
//   sits on result, and pop with empty low takes it
// each result is a byte with a run length (1 for literal bytes, 2..128 for
//   runs) and/or the row close flag with its error bit; a failed row is to
//   be dropped by the receiver
// the front decoder takes one beat per cycle while full is low and decides
//   it in that same cycle; its result is queued behind any older results
// throughput: one beat per cycle while full is low, set by the phase machine
//   in the front decoder; a four-entry result queue sits between the two sides
// when the receiver stalls, results pile up in the queue; full rises once
//   four results wait, and the input side stalls until a pop frees a slot
// row_bytes_we writes the expected decoded row size; write it between rows
// reset clears the queue, the row state and the row size register
module packbits_row_decoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  pbrd_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output pbrd_pkg::out_item_t result,
  input  logic                row_bytes_we,
  input  logic [15:0]         row_bytes
);

  // configured row size
  logic [15:0] expected_bytes;

  // front to queue
  logic                in_valid;
  logic                res_valid;
  pbrd_pkg::out_item_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_bytes <= 16'd0;
    end else if (row_bytes_we) begin
      expected_bytes <= row_bytes;
    end
  end

  // a beat is taken only while the queue has room
  assign in_valid = push && !full;

  // front: phase machine, run/literal classification and size check
  pbrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .item      (item),
    .row_bytes (expected_bytes),
    .res_valid (res_valid),
    .res       (res)
  );

  // back: result queue toward the receiver
  pbrd_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .full    (full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule
